// ===== src/sacl_pkg.sv =====
// Package for the set-associative LRU cache tag model.
// Holds payload structs, access and register codes, controller state and
// control/status bundles shared by the controller, datapath and top level.
package sacl_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int WAYS_DEF         = 4;
  localparam int ADDR_BITS_DEF    = 64;

  // Field and register widths
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 32;
  localparam int SET_BITS_W = 3;
  localparam int OFF_BITS_W = 6;
  localparam int WAYS_CFG_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SHIFT_W    = 8;

  // Register reset values
  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
  localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 6'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 3'd1;

  // Access kinds: load (L), store (S), modify (M), instruction fetch (I)
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_FETCH  = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS = 2'd0,
    REG_OFF_BITS = 2'd1,
    REG_WAYS     = 2'd2
  } cfg_reg_e;

  // Controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } ctrl_state_e;

  // One access beat
  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
  } cache_in_t;

  // One result beat
  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             did_evict;
    logic             modify_second_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } cache_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the access and start the set read
    logic commit;   // write the set back and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fetch;     // incoming beat is an instruction fetch
    logic out_free;  // result register can take a new beat this cycle
  } dp_status_t;

endpackage

// ===== src/sacl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sacl_ctrl.sv =====
// Controller of the cache tag model: sequences capture and commit of each access.
// Depends on sacl_pkg for states and the command/status bundles.
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // take any beat; drop fetches on the spot
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.fetch) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // finish once the result register has room
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A captured access blocks the input until it commits
  a_capture_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("input ready right after capture");

  // Commit only follows a capture
  a_commit_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && $past(state_q) == ST_IDLE) |-> $past(cmd_o.capture))
    else $error("commit without a captured access");

  // Never capture and commit together
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.commit))
    else $error("capture and commit in one cycle");

endmodule

// ===== src/sacl_dp.sv =====
// Datapath of the cache tag model: config registers, address split, set RAM,
// valid bits, way compare, LRU ranks, saturating totals and result register.
// Depends on sacl_pkg and sacl_ram.
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int WAYS         = WAYS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cache_in_t             in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output cache_out_t            out_data_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W    = RANK_W;
  localparam int LINE_W   = ADDR_BITS + RANK_W;
  localparam int ROW_W    = WAYS * LINE_W;

  logic [SET_BITS_W-1:0] set_bits_q;
  logic [OFF_BITS_W-1:0] off_bits_q;
  logic [WAYS_CFG_W-1:0] ways_q;

  logic [SET_BITS_W-1:0] sbits;
  logic [ADDR_BITS-1:0]  addr_cut;
  logic [ADDR_BITS-1:0]  addr_sh;
  logic [IDX_W-1:0]      set_keep;
  logic [IDX_W-1:0]      set_in;
  logic [SHIFT_W-1:0]    tag_amt;
  logic [ADDR_BITS-1:0]  tag_in;

  logic [IDX_W-1:0]      set_q;
  logic [ADDR_BITS-1:0]  tag_q;
  logic                  modify_q;

  logic [ROW_W-1:0]      row_rd;
  logic [ROW_W-1:0]      row_new;
  logic [ADDR_BITS-1:0]  tag_rd  [WAYS];
  logic [RANK_W-1:0]     rank_rd [WAYS];

  logic [NUM_SETS-1:0][WAYS-1:0] valid_q;
  logic [WAYS-1:0]       vrow;
  logic [WAYS-1:0]       active;
  logic [WAYS-1:0]       match;

  logic                  hit;
  logic                  any_free;
  logic                  evict;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      victim;
  logic [RANK_W-1:0]     victim_rank;
  logic [WAY_W-1:0]      target;
  logic                  tgt_valid;
  logic [RANK_W-1:0]     tgt_rank;

  logic [CNT_W-1:0]      hits_q, misses_q, evicts_q;
  logic [CNT_W-1:0]      hits_nx, misses_nx, evicts_nx;
  logic [1:0]            hit_inc;
  logic [CNT_W:0]        hits_sum;

  logic                  out_valid_q;
  cache_out_t            out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= SET_BITS_RST;
      off_bits_q <= OFF_BITS_RST;
      ways_q     <= WAYS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SET_BITS: set_bits_q <= cfg_data_i[SET_BITS_W-1:0];
        REG_OFF_BITS: off_bits_q <= cfg_data_i[OFF_BITS_W-1:0];
        REG_WAYS:     ways_q     <= cfg_data_i[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Split the incoming address into set and tag
  always_comb begin
    sbits    = (int'(set_bits_q) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
    addr_cut = in_data_i.address[ADDR_BITS-1:0];
    addr_sh  = addr_cut >> off_bits_q;
    set_keep = ~({IDX_W{1'b1}} << sbits);
    set_in   = addr_sh[IDX_W-1:0] & set_keep;
    tag_amt  = SHIFT_W'(off_bits_q) + SHIFT_W'(sbits);
    tag_in   = addr_cut >> tag_amt;
  end

  // Latch the access on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q    <= set_in;
      tag_q    <= tag_in;
      modify_q <= (in_data_i.mode == MODE_MODIFY);
    end
  end

  // Set row store: tag and rank of every way
  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(set_q),
    .wdata_i(row_new),
    .re_i   (cmd_i.capture),
    .raddr_i(set_in),
    .rdata_o(row_rd)
  );

  // Unpack the row and mark the ways in use
  always_comb begin
    vrow = valid_q[set_q];
    for (int w = 0; w < WAYS; w++) begin
      tag_rd[w]  = row_rd[w*LINE_W +: ADDR_BITS];
      rank_rd[w] = row_rd[w*LINE_W + ADDR_BITS +: RANK_W];
      active[w]  = (w == 0) || (w < int'(ways_q));
      match[w]   = active[w] && vrow[w] && (tag_rd[w] == tag_q);
    end
  end

  // Pick the hit way, the first free way and the oldest way
  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    any_free    = 1'b0;
    free_way    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (active[w] && !vrow[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    victim      = '0;
    victim_rank = rank_rd[0];
    for (int w = 1; w < WAYS; w++) begin
      if (active[w] && rank_rd[w] > victim_rank) begin
        victim      = WAY_W'(w);
        victim_rank = rank_rd[w];
      end
    end
    evict     = !hit && !any_free;
    target    = hit ? hit_way : (any_free ? free_way : victim);
    tgt_valid = vrow[target];
    tgt_rank  = rank_rd[target];
  end

  // Build the updated row: age younger lines, refresh the target
  always_comb begin
    row_new = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        row_new[w*LINE_W + ADDR_BITS +: RANK_W] = '0;
        if (!hit) begin
          row_new[w*LINE_W +: ADDR_BITS] = tag_q;
        end
      end else if (active[w] && vrow[w] && (!tgt_valid || rank_rd[w] < tgt_rank) &&
                   rank_rd[w] < RANK_W'(WAYS - 1)) begin
        row_new[w*LINE_W + ADDR_BITS +: RANK_W] = rank_rd[w] + 1'b1;
      end
    end
  end

  // Saturating totals
  always_comb begin
    hit_inc   = {1'b0, hit} + {1'b0, modify_q};
    hits_sum  = {1'b0, hits_q} + (CNT_W + 1)'(hit_inc);
    hits_nx   = hits_sum[CNT_W] ? '1 : hits_sum[CNT_W-1:0];
    misses_nx = (!hit && misses_q != '1) ? misses_q + 1'b1 : misses_q;
    evicts_nx = (evict && evicts_q != '1) ? evicts_q + 1'b1 : evicts_q;
  end

  // Valid bits and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[set_q][target] <= 1'b1;
      hits_q                 <= hits_nx;
      misses_q               <= misses_nx;
      evicts_q               <= evicts_nx;
    end
  end

  // Result register: load on commit, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q.was_hit           <= hit;
      out_data_q.was_miss          <= !hit;
      out_data_q.did_evict         <= evict;
      out_data_q.modify_second_hit <= modify_q;
      out_data_q.hit_total         <= hits_nx;
      out_data_q.miss_total        <= misses_nx;
      out_data_q.eviction_total    <= evicts_nx;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.fetch    = (in_data_i.mode == MODE_FETCH);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Commit never overwrites a result still waiting
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // The committed way is valid afterwards
  a_target_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> valid_q[$past(set_q)][$past(target)])
    else $error("committed line not valid");

  // Totals never go down
  a_totals_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)) &&
             (evicts_q >= $past(evicts_q)))
    else $error("a total decreased");

endmodule

// ===== src/set_assoc_lru_cache_tag_model.sv =====
// Set-associative cache tag model with LRU replacement, top level.
// Channels: in (mode, address), out (hit/miss/evict flags and running
// totals), and a config write port (index 0 set bits, 1 offset bits, 2 ways).
// Each data access passes through the idle and lookup states: the set row
// (tags and ranks of all ways) is read from one RAM in the accept cycle, then
// compared, updated and written back in the lookup state, which also loads
// the result register. The result beat is registered; no new access is
// accepted until the current one has been written back.
// Instruction fetches are accepted in the idle state and give no result beat.
// If the receiver stalls, the result register holds its beat and a further
// access waits in the lookup cycle until the register frees up.
// Reset clears the valid bits and totals at once (no clearing pass; the tag
// and rank of a line count only once it is valid), and loads the registers
// with 4 set bits, 4 offset bits and 1 way.
// Config writes are always accepted; write them only while the block is idle.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp and sacl_ram.
module set_assoc_lru_cache_tag_model
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int WAYS         = WAYS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cache_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cache_out_t            out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Config writes complete on valid
  assign cfg_ready_o = 1'b1;

  // Access sequencing
  sacl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Lookup and update
  sacl_dp #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS        (WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the set-associative LRU cache tag model.
// Directed table then phased random accesses, checked beat by beat against
// an in-bench LRU predictor. Depends on sacl_pkg and the top-level RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  localparam int MAX_SET       = MAX_SET_BITS_DEF;
  localparam int NWAYS         = WAYS_DEF;
  localparam int NUM_LINES     = (1 << MAX_SET) * NWAYS;
  localparam int RAND_ITEMS    = 1400;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT         = 1000000;
  localparam int MAX_PRINTS    = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit                    is_write;
    mode_e                 mode;
    logic [ADDR_W-1:0]     address;
    bit                    fixed;
    cache_out_t            res;
    logic [CFG_IDX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] value;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  cache_in_t             in_data = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  cache_out_t            out_data_o;
  logic                  cfg_ready_o;

  // Expectation typed into the table travels with its access beat
  bit                    fixed_due = 1'b0;
  cache_out_t            fixed_res = '0;

  // Predictor state
  logic [ADDR_W-1:0]     tag_mem   [NUM_LINES];
  bit                    valid_mem [NUM_LINES];
  int unsigned           age_mem   [NUM_LINES];
  logic [CNT_W-1:0]      hit_cnt = '0;
  logic [CNT_W-1:0]      miss_cnt = '0;
  logic [CNT_W-1:0]      evict_cnt = '0;
  int unsigned           set_bits_m = SET_BITS_RST;
  int unsigned           off_bits_m = OFF_BITS_RST;
  int unsigned           ways_m = WAYS_RST;

  cache_out_t            results_due [$];
  plan_row_t             plan [$];
  int unsigned           errors = 0;
  int unsigned           beats_out = 0;
  int unsigned           cycles = 0;

  set_assoc_lru_cache_tag_model dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cache_out_t tallies(bit h, bit m, bit e, bit md,
                                         int unsigned ht, int unsigned mt,
                                         int unsigned et);
    cache_out_t r;
    r.was_hit           = h;
    r.was_miss          = m;
    r.did_evict         = e;
    r.modify_second_hit = md;
    r.hit_total         = ht;
    r.miss_total        = mt;
    r.eviction_total    = et;
    return r;
  endfunction

  function automatic plan_row_t access_row(mode_e m, logic [ADDR_W-1:0] a);
    plan_row_t row;
    row.is_write = 1'b0;
    row.mode     = m;
    row.address  = a;
    row.fixed    = 1'b0;
    row.res      = '0;
    row.sel      = '0;
    row.value    = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(mode_e m, logic [ADDR_W-1:0] a,
                                            cache_out_t r);
    plan_row_t row;
    row       = access_row(m, a);
    row.fixed = 1'b1;
    row.res   = r;
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DATA_W-1:0] v);
    plan_row_t row;
    row          = access_row(MODE_LOAD, '0);
    row.is_write = 1'b1;
    row.sel      = sel;
    row.value    = v;
    return row;
  endfunction

  // Look up one data access, update ways, ranks and totals
  task automatic model_access(input cache_in_t beat, output cache_out_t res);
    int unsigned sb, nw, base, tgt, old_age, w;
    logic [ADDR_W-1:0] set_v, tag_v;
    bit hit, evict, free_way;
    sb = (set_bits_m > MAX_SET) ? MAX_SET : set_bits_m;
    nw = (ways_m == 0) ? 1 : ((ways_m > NWAYS) ? NWAYS : ways_m);
    // Shifts of the full width or more leave nothing
    set_v = (off_bits_m >= ADDR_W) ? '0 : (beat.address >> off_bits_m);
    set_v &= (64'd1 << sb) - 64'd1;
    tag_v = (off_bits_m + sb >= ADDR_W) ? '0 : (beat.address >> (off_bits_m + sb));
    base  = int'(set_v) * NWAYS;
    hit   = 1'b0;
    evict = 1'b0;
    tgt   = 0;
    for (w = 0; w < nw; w++)
      if (!hit && valid_mem[base+w] && tag_mem[base+w] == tag_v) begin
        hit = 1'b1;
        tgt = w;
      end
    // Fill the lowest invalid way, else the oldest, lowest way on a tie
    if (!hit) begin
      free_way = 1'b0;
      for (w = 0; w < nw; w++)
        if (!free_way && !valid_mem[base+w]) begin
          free_way = 1'b1;
          tgt = w;
        end
      if (!free_way) begin
        tgt = 0;
        for (w = 1; w < nw; w++)
          if (age_mem[base+w] > age_mem[base+tgt]) tgt = w;
        evict = 1'b1;
      end
    end
    // Age the lines younger than the touched one
    old_age = valid_mem[base+tgt] ? age_mem[base+tgt] : NWAYS;
    for (w = 0; w < nw; w++)
      if (w != tgt && valid_mem[base+w] && age_mem[base+w] < old_age &&
          age_mem[base+w] < NWAYS - 1)
        age_mem[base+w]++;
    age_mem[base+tgt] = 0;
    if (hit) begin
      if (hit_cnt != '1) hit_cnt++;
    end else begin
      if (miss_cnt != '1) miss_cnt++;
      if (evict && evict_cnt != '1) evict_cnt++;
      tag_mem[base+tgt]   = tag_v;
      valid_mem[base+tgt] = 1'b1;
    end
    if (beat.mode == MODE_MODIFY && hit_cnt != '1) hit_cnt++;
    res = tallies(hit, !hit, evict, beat.mode == MODE_MODIFY,
                  hit_cnt, miss_cnt, evict_cnt);
  endtask

  task automatic report_miss(string what, logic [63:0] got_v, logic [63:0] want_v);
    if (errors < MAX_PRINTS)
      $display("mismatch at cycle %0d, %s: got %0h, want %0h", cycles, what, got_v, want_v);
    errors++;
  endtask

  task automatic check_result(cache_out_t got, cache_out_t want);
    if (got.was_hit !== want.was_hit)
      report_miss("was_hit", got.was_hit, want.was_hit);
    if (got.was_miss !== want.was_miss)
      report_miss("was_miss", got.was_miss, want.was_miss);
    if (got.did_evict !== want.did_evict)
      report_miss("did_evict", got.did_evict, want.did_evict);
    if (got.modify_second_hit !== want.modify_second_hit)
      report_miss("modify_second_hit", got.modify_second_hit, want.modify_second_hit);
    if (got.hit_total !== want.hit_total)
      report_miss("hit_total", got.hit_total, want.hit_total);
    if (got.miss_total !== want.miss_total)
      report_miss("miss_total", got.miss_total, want.miss_total);
    if (got.eviction_total !== want.eviction_total)
      report_miss("eviction_total", got.eviction_total, want.eviction_total);
  endtask

  // Compare result beats first, then take config and access beats
  always @(posedge clk_i) begin : scoreboard
    cache_out_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        beats_out++;
        if (results_due.size() == 0)
          report_miss("result beat with nothing due, hit_total", out_data_o.hit_total, '0);
        else
          check_result(out_data_o, results_due.pop_front());
      end
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          REG_SET_BITS: set_bits_m = cfg_data & 6'h07;
          REG_OFF_BITS: off_bits_m = cfg_data;
          REG_WAYS:     ways_m     = cfg_data & 6'h07;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o && in_data.mode != MODE_FETCH) begin
        model_access(in_data, pred);
        results_due.push_back(fixed_due ? fixed_res : pred);
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs to back the block up
  initial begin : receiver
    int unsigned n, holds;
    holds = 0;
    @(posedge rst_ni);
    forever begin
      if (holds < 2 && beats_out >= 150 + holds * 750) begin
        holds++;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      repeat (n) @(posedge clk_i);
      n = idle_len();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic offer_access(input mode_e m, input logic [ADDR_W-1:0] a,
                              input bit fixed, input cache_out_t res);
    cache_in_t beat;
    beat.mode    = m;
    beat.address = a;
    in_valid  <= 1'b1;
    in_data   <= beat;
    fixed_due <= fixed;
    fixed_res <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait out every due result and any fetch still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: directed table, then random phases
  initial begin : sender
    int unsigned gap, phase, sent, n, r, sbe, nwe, offs, sb_pick, nw_pick;
    logic [CFG_DATA_W-1:0] v;
    logic [ADDR_W-1:0] a, tag_v, set_v, pool_base;
    mode_e m;
    bit quiet;

    // Reset config: 4 set bits, 4 offset bits, one way
    plan.push_back(checked_row(MODE_LOAD, 64'h0, tallies(0, 1, 0, 0, 0, 1, 0)));
    plan.push_back(checked_row(MODE_LOAD, 64'h0, tallies(1, 0, 0, 0, 1, 1, 0)));
    plan.push_back(checked_row(MODE_STORE, 64'hF, tallies(1, 0, 0, 0, 2, 1, 0)));
    plan.push_back(checked_row(MODE_MODIFY, 64'h0, tallies(1, 0, 0, 1, 4, 1, 0)));
    plan.push_back(access_row(MODE_FETCH, '1));
    plan.push_back(checked_row(MODE_LOAD, 64'h100, tallies(0, 1, 1, 0, 4, 2, 1)));
    plan.push_back(checked_row(MODE_LOAD, '1, tallies(0, 1, 0, 0, 4, 3, 1)));
    plan.push_back(checked_row(MODE_MODIFY, 64'h0, tallies(0, 1, 1, 1, 5, 4, 2)));
    plan.push_back(checked_row(MODE_STORE, '1, tallies(1, 0, 0, 0, 6, 4, 2)));
    // Full associativity: fill set 0, then evict its oldest line
    plan.push_back(write_row(REG_WAYS, 6'd4));
    plan.push_back(access_row(MODE_LOAD, 64'h000));
    plan.push_back(access_row(MODE_LOAD, 64'h100));
    plan.push_back(access_row(MODE_LOAD, 64'h200));
    plan.push_back(access_row(MODE_LOAD, 64'h300));
    plan.push_back(access_row(MODE_LOAD, 64'h400));
    plan.push_back(access_row(MODE_STORE, 64'h100));
    // Unused index, then values past the top: clamp set bits and ways
    plan.push_back(write_row(REG_UNUSED, 6'h3F));
    plan.push_back(write_row(REG_WAYS, 6'd7));
    plan.push_back(write_row(REG_SET_BITS, 6'd7));
    plan.push_back(write_row(REG_OFF_BITS, 6'd63));
    plan.push_back(access_row(MODE_LOAD, 64'h8000_0000_0000_0000));
    plan.push_back(access_row(MODE_STORE, 64'h0));
    plan.push_back(access_row(MODE_MODIFY, 64'h8000_0000_0000_0001));
    // Zero everywhere: ways of zero acts as one, whole address is the tag
    plan.push_back(write_row(REG_SET_BITS, 6'd0));
    plan.push_back(write_row(REG_OFF_BITS, 6'd0));
    plan.push_back(write_row(REG_WAYS, 6'd0));
    plan.push_back(access_row(MODE_LOAD, '1));
    plan.push_back(access_row(MODE_LOAD, 64'h0));
    plan.push_back(access_row(MODE_MODIFY, 64'h1));
    plan.push_back(access_row(MODE_FETCH, 64'h0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        gap = idle_len();
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        offer_access(plan[i].mode, plan[i].address, plan[i].fixed, plan[i].res);
      end
    end

    // Random phases, each under a fresh setting
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      case (phase)
        0:       begin sb_pick = 6; offs = 32; nw_pick = 4; end
        1:       begin sb_pick = 6; offs = 0;  nw_pick = 4; end
        2:       begin sb_pick = 0; offs = 4;  nw_pick = 2; end
        default: begin
          sb_pick = $urandom_range(0, 7);
          offs    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
          nw_pick = $urandom_range(0, 7);
        end
      endcase
      settle();
      // Upper data bits are don't-care for the narrow registers
      v = CFG_DATA_W'($urandom);
      v[2:0] = 3'(sb_pick);
      write_reg(REG_SET_BITS, v);
      write_reg(REG_OFF_BITS, CFG_DATA_W'(offs));
      v = CFG_DATA_W'($urandom);
      v[2:0] = 3'(nw_pick);
      write_reg(REG_WAYS, v);
      sbe = (sb_pick > MAX_SET) ? MAX_SET : sb_pick;
      nwe = (nw_pick == 0) ? 1 : ((nw_pick > NWAYS) ? NWAYS : nw_pick);
      pool_base = {$urandom, $urandom};
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 140);
      repeat (n) begin
        r = $urandom_range(0, 99);
        m = mode_e'($urandom_range(0, 3));
        a = {$urandom, $urandom};
        // Most beats reuse a few tags in a few sets; the rest is noise
        if (r >= 15) begin
          tag_v = (r < 20) ? {$urandom, $urandom}
                           : (pool_base ^ 64'($urandom_range(0, nwe + 2)));
          set_v = (r < 90) ? 64'($urandom_range(0, 3)) : 64'($urandom);
          set_v &= (64'd1 << sbe) - 64'd1;
          a &= (64'd1 << offs) - 64'd1;
          a |= set_v << offs;
          if (offs + sbe < ADDR_W) a |= tag_v << (offs + sbe);
        end
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        offer_access(m, a, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
